>>> rtl/core/pfe_pkg.sv
package pfe_pkg;

  // Letter codes used by the pairing rules.
  localparam logic [4:0] LETTER_I = 5'd8;
  localparam logic [4:0] LETTER_J = 5'd9;
  localparam logic [4:0] LETTER_X = 5'd23;

  // Configuration register indexes.
  localparam logic [2:0] CFG_KEY_ROW_ZERO  = 3'd0;
  localparam logic [2:0] CFG_KEY_ROW_ONE   = 3'd1;
  localparam logic [2:0] CFG_KEY_ROW_TWO   = 3'd2;
  localparam logic [2:0] CFG_KEY_ROW_THREE = 3'd3;
  localparam logic [2:0] CFG_KEY_ROW_FOUR  = 3'd4;

  // Default key square "yabcdefgiklmnqsuvwxztroph", column 0 in the low bits.
  localparam logic [24:0] KEY_ROW_ZERO_RST  = 25'd3212312;
  localparam logic [24:0] KEY_ROW_ONE_RST   = 25'd10754212;
  localparam logic [24:0] KEY_ROW_TWO_RST   = 25'd19412363;
  localparam logic [24:0] KEY_ROW_THREE_RST = 25'd26991284;
  localparam logic [24:0] KEY_ROW_FOUR_RST  = 25'd7846451;

  // One key square row: five letter codes, index 0 is column 0.
  typedef logic [4:0][4:0] key_row_t;

  // Whole square: index 0 is row 0.
  typedef logic [4:0][4:0][4:0] key_square_t;

  typedef struct packed {
    logic [4:0] plain_letter;
    logic       message_end;
  } in_req_t;

  typedef struct packed {
    logic [4:0] cipher_first;
    logic [4:0] cipher_second;
    logic       final_pair;
  } out_req_t;

endpackage

>>> rtl/core/pfe_cipher.sv
module pfe_cipher (
  input  pfe_pkg::key_square_t key_sq,
  input  logic [4:0]           letter_a,
  input  logic [4:0]           letter_b,
  output logic [4:0]           cipher_a,
  output logic [4:0]           cipher_b
);

  logic [4:0] row_a;
  logic [4:0] col_a;
  logic [4:0] row_b;
  logic [4:0] col_b;
  logic [4:0] sel_row_a;
  logic [4:0] sel_col_a;
  logic [4:0] sel_row_b;
  logic [4:0] sel_col_b;

  // Find a letter in the square as one-hot row and column; the last match
  // in row-major order wins, and a missing letter reads as row 0, column 0.
  function automatic logic [9:0] locate(pfe_pkg::key_square_t sq, logic [4:0] letter);
    logic [4:0] row_oh;
    logic [4:0] col_oh;
    row_oh = 5'b00001;
    col_oh = 5'b00001;
    for (int r = 0; r < 5; r++) begin
      for (int c = 0; c < 5; c++) begin
        if (sq[r][c] == letter) begin
          row_oh = 5'(1 << r);
          col_oh = 5'(1 << c);
        end
      end
    end
    return {row_oh, col_oh};
  endfunction

  // Read one square entry picked by one-hot row and column.
  function automatic logic [4:0] cell_sel(pfe_pkg::key_square_t sq, logic [4:0] row_oh,
                                          logic [4:0] col_oh);
    logic [4:0] val;
    val = '0;
    for (int r = 0; r < 5; r++) begin
      for (int c = 0; c < 5; c++) begin
        if (row_oh[r] && col_oh[c]) begin
          val = val | sq[r][c];
        end
      end
    end
    return val;
  endfunction

  assign {row_a, col_a} = locate(key_sq, letter_a);
  assign {row_b, col_b} = locate(key_sq, letter_b);

  // Same row shifts right, same column shifts down, otherwise columns swap.
  // A one-hot rotate by one position is the step with wrap.
  always_comb begin
    if (row_a == row_b) begin
      sel_row_a = row_a;
      sel_row_b = row_b;
      sel_col_a = {col_a[3:0], col_a[4]};
      sel_col_b = {col_b[3:0], col_b[4]};
    end else if (col_a == col_b) begin
      sel_row_a = {row_a[3:0], row_a[4]};
      sel_row_b = {row_b[3:0], row_b[4]};
      sel_col_a = col_a;
      sel_col_b = col_b;
    end else begin
      sel_row_a = row_a;
      sel_row_b = row_b;
      sel_col_a = col_b;
      sel_col_b = col_a;
    end
  end

  assign cipher_a = cell_sel(key_sq, sel_row_a, sel_col_a);
  assign cipher_b = cell_sel(key_sq, sel_row_b, sel_col_b);

endmodule

>>> rtl/core/playfair_digraph_encrypt.sv
// Path: once the letter that completes a digraph is accepted, the digraph passes
// through the pair register, then the output register.
// Throughput: one letter per cycle while in_stall is low; a doubled pair split at the
// message end yields two digraphs and holds the pair register until both move on.
// Reset (synchronous, rst_n low): key square back to its default, no letter
// held, pair and output registers empty.
module playfair_digraph_encrypt (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [24:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  pfe_pkg::in_req_t  in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output pfe_pkg::out_req_t out_req
);

  pfe_pkg::key_row_t key_r [5];
  pfe_pkg::key_square_t key_sq;

  logic       held_valid_r;
  logic       held_valid_nxt;
  logic [4:0] held_letter_r;
  logic [4:0] held_letter_nxt;

  logic       pr_valid_r;
  logic       pr_valid_nxt;
  logic       pr_dup_r;
  logic       pr_dup_nxt;
  logic       pr_last_r;
  logic [4:0] pr_a_r;
  logic [4:0] pr_b_r;

  logic              out_valid_r;
  logic              out_valid_nxt;
  pfe_pkg::out_req_t out_req_r;

  logic       in_acc;
  logic       out_load;
  logic       pr_done;
  logic [4:0] letter;
  logic       gen_pair;
  logic [4:0] gen_a;
  logic [4:0] gen_b;
  logic       gen_last;
  logic       gen_dup;
  logic [4:0] ciph_a;
  logic [4:0] ciph_b;

  // Key square registers, written by index; unused indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r[0] <= pfe_pkg::KEY_ROW_ZERO_RST;
      key_r[1] <= pfe_pkg::KEY_ROW_ONE_RST;
      key_r[2] <= pfe_pkg::KEY_ROW_TWO_RST;
      key_r[3] <= pfe_pkg::KEY_ROW_THREE_RST;
      key_r[4] <= pfe_pkg::KEY_ROW_FOUR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pfe_pkg::CFG_KEY_ROW_ZERO:  key_r[0] <= cfg_data;
        pfe_pkg::CFG_KEY_ROW_ONE:   key_r[1] <= cfg_data;
        pfe_pkg::CFG_KEY_ROW_TWO:   key_r[2] <= cfg_data;
        pfe_pkg::CFG_KEY_ROW_THREE: key_r[3] <= cfg_data;
        pfe_pkg::CFG_KEY_ROW_FOUR:  key_r[4] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign key_sq = {key_r[4], key_r[3], key_r[2], key_r[1], key_r[0]};

  // Handshake: the pair register frees when its last digraph moves on.
  assign out_load = pr_valid_r && (!out_valid_r || !out_stall);
  assign pr_done  = out_load && !pr_dup_r;
  assign in_stall = pr_valid_r && !pr_done;
  assign in_acc   = in_valid && !in_stall;

  // Pairing rules on the incoming letter; j folds into i.
  assign letter = (in_req.plain_letter == pfe_pkg::LETTER_J) ? pfe_pkg::LETTER_I
                                                             : in_req.plain_letter;

  always_comb begin
    gen_pair        = 1'b0;
    gen_a           = letter;
    gen_b           = pfe_pkg::LETTER_X;
    gen_last        = in_req.message_end;
    gen_dup         = 1'b0;
    held_valid_nxt  = held_valid_r;
    held_letter_nxt = held_letter_r;
    if (in_acc) begin
      if (!held_valid_r) begin
        if (in_req.message_end) begin
          gen_pair = 1'b1;
        end else begin
          held_valid_nxt  = 1'b1;
          held_letter_nxt = letter;
        end
      end else if (letter == held_letter_r) begin
        // Doubled letter: pad the held one with x and keep the new one held.
        // At message end the new one is padded too, as a second digraph.
        gen_pair       = 1'b1;
        gen_dup        = in_req.message_end;
        held_valid_nxt = !in_req.message_end;
      end else begin
        gen_pair       = 1'b1;
        gen_a          = held_letter_r;
        gen_b          = letter;
        held_valid_nxt = 1'b0;
      end
    end
  end

  // Pair register control.
  always_comb begin
    pr_valid_nxt = pr_valid_r;
    pr_dup_nxt   = pr_dup_r;
    if (pr_done) begin
      pr_valid_nxt = 1'b0;
    end
    if (out_load && pr_dup_r) begin
      pr_dup_nxt = 1'b0;
    end
    if (gen_pair) begin
      pr_valid_nxt = 1'b1;
      pr_dup_nxt   = gen_dup;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
      pr_valid_r   <= 1'b0;
      pr_dup_r     <= 1'b0;
    end else begin
      held_valid_r <= held_valid_nxt;
      pr_valid_r   <= pr_valid_nxt;
      pr_dup_r     <= pr_dup_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_letter_r <= held_letter_nxt;
    if (gen_pair) begin
      pr_a_r    <= gen_a;
      pr_b_r    <= gen_b;
      pr_last_r <= gen_last;
    end
  end

  // Square lookup and digraph substitution.
  pfe_cipher u_cipher (
    .key_sq   (key_sq),
    .letter_a (pr_a_r),
    .letter_b (pr_b_r),
    .cipher_a (ciph_a),
    .cipher_b (ciph_b)
  );

  // Output register; the first of a split pair is never final.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_req_r.cipher_first  <= ciph_a;
      out_req_r.cipher_second <= ciph_b;
      out_req_r.final_pair    <= pr_last_r && !pr_dup_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;

`ifndef SYNTHESIS
  // A pending second digraph only exists inside a live pair at message end.
  a_dup_live: assert property (@(posedge clk) disable iff (!rst_n)
    pr_dup_r |-> (pr_valid_r && pr_last_r))
    else $error("split pair flag set without a final pair in flight");

  // After the first half of a split pair moves on, the second half remains.
  a_dup_second: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && pr_dup_r) |=> (pr_valid_r && !pr_dup_r))
    else $error("second digraph of a split pair was lost");

  // The first digraph of a split pair is loaded into the output without a final mark.
  a_final_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && pr_dup_r) |=> !out_req_r.final_pair)
    else $error("first digraph of a split pair marked final");
`endif

endmodule
